// File: rtl/crcfr_pkg.sv
package crcfr_pkg;

	localparam int PAYLOAD_BYTES = 12;
	localparam int FRAME_BYTES   = PAYLOAD_BYTES + 6;
	localparam int CRC_BYTES     = 4;

	localparam logic [7:0]  HDR0         = 8'hCA;
	localparam logic [7:0]  HDR1         = 8'hFE;
	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
	localparam logic [31:0] ENABLE_MAGIC = 32'hACDC6660;

	typedef logic [7:0]  byte_t;
	typedef logic [31:0] word_t;

	typedef struct packed {
		logic  enable_on;
		word_t value0_bits;
		word_t value1_bits;
	} result_t;

	// One byte of the reflected CRC-32, least significant bit first.
	function automatic word_t crc_byte(input word_t crc_in, input byte_t data);
		word_t crc;
		byte_t b;
		logic  lsb;
		crc = crc_in;
		b = data;
		for (int j = 0; j < 8; j++) begin
			lsb = b[0] ^ crc[0];
			crc = crc >> 1;
			if (lsb) begin
				crc = crc ^ CRC_POLY;
			end
			b = b >> 1;
		end
		return crc;
	endfunction

endpackage

// File: rtl/crcfr_crc_cell.sv
module crcfr_crc_cell
	import crcfr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  byte_t data,
	input  word_t crc_in,
	output word_t crc_out
);

	word_t crc_q;

	// Each cell extends its left neighbour's running CRC by the incoming byte,
	// so cell k holds the CRC of the last k + 1 bytes once that many have been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (shift) begin
			crc_q <= crc_byte(crc_in, data);
		end
	end

	assign crc_out = crc_q;

endmodule

// File: rtl/crcfr_out_stage.sv
module crcfr_out_stage
	import crcfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	input  logic    stall,
	output logic    ready,
	output logic    valid,
	output result_t held
);

	logic    valid_q;
	result_t held_q;

	assign ready = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			held_q <= result;
		end
	end

	assign valid = valid_q;
	assign held  = held_q;

endmodule

// File: rtl/crc32_checked_frame_receiver_top.sv
// Channel   Direction  Handshake            Word
// input     in         in_valid / in_stall  rx_byte
// result    out        out_valid/out_stall  enable_on, value0_bits, value1_bits
//
// A byte is taken each cycle unless stalled; twelve CRC cells advance on each byte.
// The last CRC byte enters the window; the result then loads the output register.
// The input stalls only while a matched frame waits behind a stalled output word.
// Reset clears the byte window and the CRC cells to zero; no clearing pass is needed.
module crc32_checked_frame_receiver_top
	import crcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        enable_on,
	output logic [31:0] value0_bits,
	output logic [31:0] value1_bits,
	output logic        out_valid,
	input  logic        out_stall
);

	byte_t   win_q [FRAME_BYTES];
	word_t   crc_chain [PAYLOAD_BYTES + 1];
	word_t   crc_dly_q [CRC_BYTES];
	logic    fresh_q;
	logic    in_accept;
	logic    frame_ok;
	logic    out_ready;
	logic    load;
	result_t result;
	result_t held;

	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				win_q[i] <= '0;
			end
			for (int i = 0; i < CRC_BYTES; i++) begin
				crc_dly_q[i] <= '0;
			end
		end else if (in_accept) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[FRAME_BYTES - 1] <= rx_byte;
			// The payload CRC is complete four bytes before the frame ends.
			crc_dly_q[0] <= crc_chain[PAYLOAD_BYTES];
			for (int i = 1; i < CRC_BYTES; i++) begin
				crc_dly_q[i] <= crc_dly_q[i - 1];
			end
		end
	end

	assign crc_chain[0] = CRC_INIT;

	for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_cell
		crcfr_crc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (in_accept),
			.data    (rx_byte),
			.crc_in  (crc_chain[k]),
			.crc_out (crc_chain[k + 1])
		);
	end

	assign frame_ok = (win_q[0] == HDR0) && (win_q[1] == HDR1) &&
		(~crc_dly_q[CRC_BYTES - 1] == {win_q[PAYLOAD_BYTES + 5], win_q[PAYLOAD_BYTES + 4],
			win_q[PAYLOAD_BYTES + 3], win_q[PAYLOAD_BYTES + 2]});

	assign result.enable_on   = ({win_q[5], win_q[4], win_q[3], win_q[2]} == ENABLE_MAGIC);
	assign result.value0_bits = {win_q[9], win_q[8], win_q[7], win_q[6]};
	assign result.value1_bits = {win_q[13], win_q[12], win_q[11], win_q[10]};

	assign load     = fresh_q && frame_ok;
	assign in_stall = load && !out_ready;

	// A freshly shifted window is checked once; it stays pending only while its
	// result cannot yet enter the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q <= 1'b0;
		end else if (in_accept) begin
			fresh_q <= 1'b1;
		end else if (!load || out_ready) begin
			fresh_q <= 1'b0;
		end
	end

	crcfr_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.result (result),
		.stall  (out_stall),
		.ready  (out_ready),
		.valid  (out_valid),
		.held   (held)
	);

	assign enable_on   = held.enable_on;
	assign value0_bits = held.value0_bits;
	assign value1_bits = held.value1_bits;

endmodule

// File: rtl/crcfr_checker.sv
module crcfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        enable_on,
	input logic [31:0] value0_bits,
	input logic [31:0] value1_bits,
	input logic        out_valid,
	input logic        out_stall
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(enable_on) && $stable(value0_bits) &&
			$stable(value1_bits))
		else $error("stalled result word changed");

	// The input side may only be held back by a full, stalled output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// A new result follows its completing byte via the window and the output register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without a completing byte");

endmodule

bind crc32_checked_frame_receiver_top crcfr_checker u_crcfr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.enable_on   (enable_on),
	.value0_bits (value0_bits),
	.value1_bits (value1_bits),
	.out_valid   (out_valid),
	.out_stall   (out_stall)
);
